// ===== design/aprm_pkg.sv =====
// Shared constants and types for the peak / RMS / mean-abs level meter.
`timescale 1ns / 1ps
package aprm_pkg;

  localparam int unsigned SMP_W       = 16;        // PCM sample width
  localparam int unsigned SQ_W        = 55;        // sum of squares
  localparam int unsigned MAG_W       = 40;        // sum of magnitudes
  localparam int unsigned CNT_W       = 25;        // sample counter
  localparam int unsigned MAX_SAMPLES = 16777216;  // samples taken per run
  localparam int unsigned UNIT_W      = 32;        // shared subtract/compare width
  localparam int unsigned MS_W        = 31;        // mean square, up to 2^30
  localparam int unsigned DIV_STEPS   = SQ_W;      // one quotient bit per step
  localparam int unsigned SQRT_STEPS  = 16;        // one root bit per step
  localparam int unsigned STEP_W      = 6;         // holds DIV_STEPS - 1
  localparam int unsigned RES_W       = 16;        // result field width

  typedef struct packed {
    logic             start;
    logic [SQ_W-1:0]  square_sum;
    logic [MAG_W-1:0] magnitude_sum;
    logic [CNT_W-1:0] count;
  } aprm_solve_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] rms;
    logic [RES_W-1:0] mean_abs;
  } aprm_solve_rsp_t;

endpackage

// ===== design/aprm_subcmp.sv =====
// Shared subtract-and-compare unit used by the divider and the square root.
`timescale 1ns / 1ps
module aprm_subcmp import aprm_pkg::*; (
  input  logic [UNIT_W-1:0] a_i,
  input  logic [UNIT_W-1:0] b_i,
  output logic [UNIT_W-1:0] diff_o,
  output logic              ge_o
);

  logic [UNIT_W:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[UNIT_W-1:0];
  assign ge_o   = ~full[UNIT_W];

endmodule

// ===== design/aprm_solver.sv =====
// End-of-run sequencer: two restoring divisions and a bitwise square root.
`timescale 1ns / 1ps
module aprm_solver import aprm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aprm_solve_req_t req_i,
  output aprm_solve_rsp_t rsp_o
);

  typedef enum logic [1:0] {S_IDLE, S_DIV_SQ, S_DIV_MAG, S_SQRT} state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SQ_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [MS_W-1:0]   ms_q, ms_d;
  logic [MS_W-1:0]   root_q, root_d;
  logic [MS_W-1:0]   bit_q, bit_d;
  logic [RES_W-1:0]  mean_q, mean_d;
  logic              done_q, done_d;

  logic [CNT_W:0]    rem_shift;
  logic [UNIT_W-1:0] op_a, op_b, diff;
  logic              ge;
  logic              div_last, sqrt_last;

  assign rem_shift = {rem_q, dvd_q[SQ_W-1]};
  assign div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
  assign sqrt_last = (step_q == STEP_W'(SQRT_STEPS - 1));

  always_comb begin
    if (state_q == S_SQRT) begin
      op_a = {1'b0, ms_q};
      op_b = {1'b0, root_q | bit_q};
    end else begin
      op_a = {{(UNIT_W-CNT_W-1){1'b0}}, rem_shift};
      op_b = {{(UNIT_W-CNT_W){1'b0}}, req_i.count};
    end
  end

  aprm_subcmp u_subcmp (
    .a_i    (op_a),
    .b_i    (op_b),
    .diff_o (diff),
    .ge_o   (ge)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    ms_d    = ms_q;
    root_d  = root_q;
    bit_d   = bit_q;
    mean_d  = mean_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          dvd_d   = req_i.square_sum;
          rem_d   = '0;
          step_d  = '0;
          state_d = S_DIV_SQ;
        end
      end
      S_DIV_SQ, S_DIV_MAG: begin
        // remainder stays below the count, so it fits CNT_W bits
        rem_d  = ge ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        dvd_d  = {dvd_q[SQ_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (div_last) begin
          step_d = '0;
          if (state_q == S_DIV_SQ) begin
            ms_d    = {dvd_q[MS_W-2:0], ge};
            dvd_d   = {{(SQ_W-MAG_W){1'b0}}, req_i.magnitude_sum};
            rem_d   = '0;
            state_d = S_DIV_MAG;
          end else begin
            mean_d  = {dvd_q[RES_W-2:0], ge};
            root_d  = '0;
            bit_d   = {1'b1, {(MS_W-1){1'b0}}};
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        // root and bit never overlap, so root + bit is root | bit
        if (ge) begin
          ms_d   = diff[MS_W-1:0];
          root_d = (root_q >> 1) | bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 1'b1;
        if (sqrt_last) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    ms_q   <= ms_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    mean_q <= mean_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rms      = root_q[RES_W-1:0];
  assign rsp_o.mean_abs = mean_q;

endmodule

// ===== design/audio_peak_rms_meanabs_meter.sv =====
// Top level: sample accumulation, end-of-run solve and output register.
// A plain sample occupies the input through the accept, square and add states.
// A sample marked last then runs the solve: 55 + 55 restoring-divide steps and
// 16 root steps, all on one shared subtract/compare unit, then the output load.
// The input takes no new sample until the previous one is added; one result per run.
// Reset (rst_ni, async, active low) clears all run accumulators and both valids.
`timescale 1ns / 1ps
module audio_peak_rms_meanabs_meter import aprm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample (signed)
  input  logic        s_axis_tlast,   // last sample of the run
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] peak, [31:16] rms, [47:32] mean_abs
  output logic        m_axis_tuser    // [0] overflow
);

  // T_IDLE is the only state that takes a request; the output register is
  // separate, so a finished result can wait while the next run accumulates.
  typedef enum logic [2:0] {T_IDLE, T_SQ, T_ADD, T_SOLVE, T_OUT} state_e;

  state_e             state_q, state_d;
  logic [SMP_W-1:0]   mag_q, mag_d;
  logic               last_q, last_d;
  logic               take_q, take_d;
  logic [2*SMP_W-1:0] sq_q, sq_d;
  logic [SMP_W-1:0]   peak_q, peak_d;
  logic [SQ_W-1:0]    ssum_q, ssum_d;
  logic [MAG_W-1:0]   msum_q, msum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               zero_q, zero_d;
  logic               start_q, start_d;
  logic               m_valid_q, m_valid_d;
  logic [RES_W-1:0]   o_peak_q, o_peak_d;
  logic [RES_W-1:0]   o_rms_q, o_rms_d;
  logic [RES_W-1:0]   o_mean_q, o_mean_d;
  logic               o_ovf_q, o_ovf_d;

  logic               in_fire;
  logic               out_free;
  logic [SMP_W-1:0]   in_mag;
  aprm_solve_req_t    sreq;
  aprm_solve_rsp_t    srsp;

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // -32768 wraps to 0x8000, which is 32768 as an unsigned magnitude
  assign in_mag = s_axis_tdata[SMP_W-1] ? (SMP_W'(0) - s_axis_tdata) : s_axis_tdata;

  assign sreq.start         = start_q;
  assign sreq.square_sum    = ssum_q;
  assign sreq.magnitude_sum = msum_q;
  assign sreq.count         = cnt_q;

  aprm_solver u_solver (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rsp_o  (srsp)
  );

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    last_d    = last_q;
    take_d    = take_q;
    sq_d      = sq_q;
    peak_d    = peak_q;
    ssum_d    = ssum_q;
    msum_d    = msum_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    zero_d    = zero_q;
    start_d   = 1'b0;
    m_valid_d = m_valid_q & ~m_axis_tready;
    o_peak_d  = o_peak_q;
    o_rms_d   = o_rms_q;
    o_mean_d  = o_mean_q;
    o_ovf_d   = o_ovf_q;
    case (state_q)
      T_IDLE: begin
        if (in_fire) begin
          mag_d   = in_mag;
          last_d  = s_axis_tlast;
          // past the sample limit a sample only marks overflow
          take_d  = (cnt_q < CNT_W'(MAX_SAMPLES));
          if (cnt_q >= CNT_W'(MAX_SAMPLES)) ovf_d = 1'b1;
          state_d = T_SQ;
        end
      end
      T_SQ: begin
        sq_d = {{SMP_W{1'b0}}, mag_q} * {{SMP_W{1'b0}}, mag_q};
        if (take_q && (mag_q > peak_q)) peak_d = mag_q;
        state_d = T_ADD;
      end
      T_ADD: begin
        if (take_q) begin
          ssum_d = ssum_q + {{(SQ_W-2*SMP_W){1'b0}}, sq_q};
          msum_d = msum_q + {{(MAG_W-SMP_W){1'b0}}, mag_q};
          cnt_d  = cnt_q + 1'b1;
        end
        if (!last_q) begin
          state_d = T_IDLE;
        end else if (cnt_d == '0) begin
          // empty run: no divide, rms and mean read as zero
          zero_d  = 1'b1;
          state_d = T_OUT;
        end else begin
          zero_d  = 1'b0;
          start_d = 1'b1;
          state_d = T_SOLVE;
        end
      end
      T_SOLVE: begin
        if (srsp.done) state_d = T_OUT;
      end
      T_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          o_peak_d  = peak_q;
          o_rms_d   = zero_q ? '0 : srsp.rms;
          o_mean_d  = zero_q ? '0 : srsp.mean_abs;
          o_ovf_d   = ovf_q;
          // clear the run for the next one
          peak_d    = '0;
          ssum_d    = '0;
          msum_d    = '0;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          state_d   = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      peak_q    <= '0;
      ssum_q    <= '0;
      msum_q    <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      zero_q    <= 1'b0;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      peak_q    <= peak_d;
      ssum_q    <= ssum_d;
      msum_q    <= msum_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      zero_q    <= zero_d;
      start_q   <= start_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    last_q   <= last_d;
    take_q   <= take_d;
    sq_q     <= sq_d;
    o_peak_q <= o_peak_d;
    o_rms_q  <= o_rms_d;
    o_mean_q <= o_mean_d;
    o_ovf_q  <= o_ovf_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_mean_q, o_rms_q, o_peak_q};
  assign m_axis_tuser  = o_ovf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a request occupies the input for the whole multi-cycle update
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input ready right after a request");

  // a new result only appears out of the output-load state
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == T_OUT))
    else $error("result valid rose outside output load");

  // the counter never passes the sample limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count past limit");

  // rms and mean magnitude can never exceed the peak magnitude
  a_result_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (o_rms_q <= o_peak_q) && (o_mean_q <= o_peak_q))
    else $error("rms or mean above peak");

endmodule
